// File: rtl/core/periodic_timer_task_table_core_macros.svh
// Assertion macros used by the timer table checker.
`ifndef PERIODIC_TIMER_TASK_TABLE_CORE_MACROS_SVH
`define PERIODIC_TIMER_TASK_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PTT_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("timer table check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PTT_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("timer table check failed");

`endif

// File: rtl/core/ptt_pkg.sv
// Package: sizes, codes, types and helpers of the timer task table.
`default_nettype none

package ptt_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int TIME_BITS  = 32;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // stream field layout
  localparam int OP_W       = 2;
  localparam int SLOT_FW    = 4;
  localparam int TV_W       = 32;
  localparam int NOW_W      = 32;
  localparam int EV_W       = 2;
  localparam int SLOT_LSB   = 0;
  localparam int TV_LSB     = SLOT_LSB + SLOT_FW;
  localparam int NOW_LSB    = TV_LSB + TV_W;
  localparam int IN_BITS    = NOW_LSB + NOW_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int FOUND_BIT  = SLOT_FW;
  localparam int OUT_BITS   = SLOT_FW + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // operations
  localparam logic [OP_W-1:0] OP_ONESHOT  = 2'd0;
  localparam logic [OP_W-1:0] OP_PERIODIC = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL   = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd3;

  // result kinds
  localparam logic [EV_W-1:0] EV_SCHED = 2'd0;
  localparam logic [EV_W-1:0] EV_CANCEL = 2'd1;
  localparam logic [EV_W-1:0] EV_FIRED = 2'd2;
  localparam logic [EV_W-1:0] EV_NONE  = 2'd3;

  // cell commands
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_FIRE  = 2'd3;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [SLOT_W-1:0]    idx_t;

  // scan token passed down the cell row
  typedef struct packed {
    logic  go;
    logic  any;
    idx_t  pos;
    idx_t  best;
    time_t dl;
  } cand_t;

  // command broadcast from the controller to the cells
  typedef struct packed {
    logic [1:0] op;
    idx_t       idx;
    time_t      deadline;
    time_t      interval;
    logic       periodic;
    time_t      now;
  } cmd_t;

  typedef struct packed {
    logic [EV_W-1:0]    ev;
    logic [SLOT_FW-1:0] slot;
    logic               found;
  } res_t;

  function automatic time_t sat_add(input time_t a, input time_t b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ptt_cell.sv
// One timer slot: stored entry, command decode and one step of the min scan.
`default_nettype none

module ptt_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           sel,
  input  wire ptt_pkg::cmd_t  cmd,
  input  wire ptt_pkg::cand_t cand_in,
  output ptt_pkg::cand_t      cand_out,
  output logic                valid
);
  import ptt_pkg::*;

  logic  valid_r;
  time_t dl_r;
  time_t iv_r;
  logic  per_r;
  logic  go_r;
  cand_t cand_r;
  cand_t cand_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel) begin
      case (cmd.op)
        CMD_SET:   valid_r <= 1'b1;
        CMD_CLEAR: valid_r <= 1'b0;
        CMD_FIRE:  valid_r <= per_r;
        default:   valid_r <= valid_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.op == CMD_SET) begin
      dl_r  <= cmd.deadline;
      iv_r  <= cmd.interval;
      per_r <= cmd.periodic;
    end else if (sel && cmd.op == CMD_FIRE && per_r) begin
      dl_r <= sat_add(cmd.now, iv_r);
    end
  end

  // strict less-than keeps the lower slot on equal deadlines
  always_comb begin
    cand_nxt     = cand_in;
    cand_nxt.pos = SLOT_W'(cand_in.pos + 1'b1);
    if (cand_in.go && valid_r && (!cand_in.any || dl_r < cand_in.dl)) begin
      cand_nxt.any  = 1'b1;
      cand_nxt.best = cand_in.pos;
      cand_nxt.dl   = dl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r <= 1'b0;
    end else begin
      go_r <= cand_nxt.go;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
  end

  always_comb begin
    cand_out    = cand_r;
    cand_out.go = go_r;
  end

  assign valid = valid_r;

endmodule

`default_nettype wire

// File: rtl/core/ptt_ctrl.sv
// Controller: input decode, scan sequencing, fire decision and result register.
`default_nettype none

module ptt_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [ptt_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic [ptt_pkg::OP_W-1:0]         in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [ptt_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic [ptt_pkg::EV_W-1:0]              out_tuser,
  input  wire logic [ptt_pkg::SLOT_COUNT-1:0]   valid_vec,
  input  wire ptt_pkg::cand_t                   chain_end,
  output ptt_pkg::cand_t                        chain_start,
  output ptt_pkg::cmd_t                         cmd
);
  import ptt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state_r, state_nxt;
  time_t      now_r;
  res_t       res_r;
  res_t       out_res_r;
  logic       out_valid_r;

  logic               in_acc;
  logic [SLOT_FW-1:0] f_slot;
  time_t              f_tv;
  time_t              f_now;
  idx_t               f_idx;
  logic               f_inside;
  logic               out_free;
  logic               due;
  logic               res_load;
  logic               res_hold;
  res_t               res_new;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign f_slot   = in_tdata[SLOT_LSB +: SLOT_FW];
  assign f_tv     = TIME_BITS'(in_tdata[TV_LSB +: TV_W]);
  assign f_now    = TIME_BITS'(in_tdata[NOW_LSB +: NOW_W]);
  assign f_inside = {{(32-SLOT_FW){1'b0}}, f_slot} < 32'(SLOT_COUNT);

  always_comb begin
    logic [SLOT_FW+SLOT_W-1:0] wide;
    wide  = {{SLOT_W{1'b0}}, f_slot};
    f_idx = wide[SLOT_W-1:0];
  end

  assign due = chain_end.any && (chain_end.dl <= now_r);

  assign chain_start = '{go: in_acc && (in_tuser == OP_TICK), any: 1'b0,
                         pos: '0, best: '0, dl: '0};

  always_comb begin
    state_nxt = state_r;
    res_new   = res_r;
    res_load  = 1'b0;
    res_hold  = 1'b0;
    cmd       = '{op: CMD_NONE, idx: f_idx, deadline: f_tv, interval: f_tv,
                  periodic: 1'b0, now: now_r};
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_new.slot = f_slot;
          case (in_tuser)
            OP_ONESHOT: begin
              res_new.ev    = EV_SCHED;
              res_new.found = f_inside;
              cmd.op        = f_inside ? CMD_SET : CMD_NONE;
              cmd.interval  = '0;
            end
            OP_PERIODIC: begin
              res_new.ev    = EV_SCHED;
              res_new.found = f_inside;
              cmd.op        = f_inside ? CMD_SET : CMD_NONE;
              cmd.deadline  = sat_add(f_now, f_tv);
              cmd.periodic  = 1'b1;
            end
            OP_CANCEL: begin
              res_new.ev    = EV_CANCEL;
              res_new.found = f_inside && valid_vec[f_idx];
              cmd.op        = f_inside ? CMD_CLEAR : CMD_NONE;
            end
            default: begin
              state_nxt = ST_SCAN;
            end
          endcase
          if (in_tuser != OP_TICK) begin
            res_load = out_free;
            res_hold = !out_free;
            if (!out_free) begin
              state_nxt = ST_HOLD;
            end
          end
        end
      end
      ST_SCAN: begin
        if (chain_end.go) begin
          if (due) begin
            res_new = '{ev: EV_FIRED, slot: SLOT_FW'(chain_end.best), found: 1'b1};
            cmd.op  = CMD_FIRE;
            cmd.idx = chain_end.best;
          end else begin
            res_new = '{ev: EV_NONE, slot: '0, found: 1'b0};
          end
          res_load  = out_free;
          res_hold  = !out_free;
          state_nxt = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r <= f_now;
    end
    if (res_hold) begin
      res_r <= res_new;
    end
    if (res_load) begin
      out_res_r <= res_new;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.ev;
  assign out_tdata  = OUT_DATA_W'({out_res_r.found, out_res_r.slot});

endmodule

`default_nettype wire

// File: rtl/core/periodic_timer_task_table_core.sv
// Top level of the periodic timer task table: controller plus a row of slot cells.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  in_     | in  | in_tvalid/tready   | tuser: opcode; tdata: slot, time_value, now
//  out_    | out | out_tvalid/tready  | tuser: event_res; tdata: fired_slot, found
//
// Schedule and cancel are handled as the item is taken; the result lands in the output
// register on the transfer edge and the next item is taken in the next cycle.
// A tick starts a scan: the scan token walks the cell row, one
// cell per cycle, and the fire decision is made when it leaves the last cell.
// A result that cannot enter a full output register is parked and the input
// stays stalled until it moves on. Synchronous active-low reset clears all
// slot valid marks and the handshake state; slot contents are not cleared.
`default_nettype none

module periodic_timer_task_table_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [3:0] slot, [35:4] time_value, [67:36] now, rest zero
  input  wire logic [ptt_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] opcode
  input  wire logic [ptt_pkg::OP_W-1:0]        in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [3:0] fired_slot, [4] found, rest zero
  output logic [ptt_pkg::OUT_DATA_W-1:0]       out_tdata,
  // [1:0] event_res
  output logic [ptt_pkg::EV_W-1:0]             out_tuser
);
  import ptt_pkg::*;

  // token chain: chain[i] feeds cell i, chain[SLOT_COUNT] returns to control
  cand_t                 chain [SLOT_COUNT+1];
  cmd_t                  cmd;
  logic [SLOT_COUNT-1:0] valid_vec;

  ptt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .valid_vec   (valid_vec),
    .chain_end   (chain[SLOT_COUNT]),
    .chain_start (chain[0]),
    .cmd         (cmd)
  );

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    logic sel;
    // command goes only to the addressed slot
    assign sel = (cmd.op != CMD_NONE) && (cmd.idx == SLOT_W'(i));

    ptt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .sel      (sel),
      .cmd      (cmd),
      .cand_in  (chain[i]),
      .cand_out (chain[i+1]),
      .valid    (valid_vec[i])
    );
  end

endmodule

`default_nettype wire

// File: rtl/core/ptt_checker.sv
// Port-level checker for the timer task table, bound to the top level.
`default_nettype none

`include "periodic_timer_task_table_core_macros.svh"

module ptt_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic [ptt_pkg::OP_W-1:0]      in_tuser,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [ptt_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [ptt_pkg::EV_W-1:0]      out_tuser
);
  import ptt_pkg::*;

  // a stalled result holds
  `PTT_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // an idle tick carries no slot and no found mark
  `PTT_ASSERT_NOW(a_none_empty, out_tvalid && out_tuser == EV_NONE, out_tdata == '0)

  // a fired slot is always reported as found
  `PTT_ASSERT_NOW(a_fire_found, out_tvalid && out_tuser == EV_FIRED, out_tdata[FOUND_BIT])

  // a tick transfer starts a scan, so the input stalls next cycle
  `PTT_ASSERT_NXT(a_tick_busy, in_tvalid && in_tready && in_tuser == OP_TICK, !in_tready)

endmodule

bind periodic_timer_task_table_core ptt_checker u_ptt_checker (.*);

`default_nettype wire
